>>> rtl/core/ib_rot_pkg.sv
// Package for the inertial to body-fixed rotation block.
// Holds payload structs, fixed-point constants and the CORDIC arctangent table.
// No dependencies.
package ib_rot_pkg;

  localparam int TRIG_ITERATIONS_DEF = 24;
  localparam int MAX_ITERATIONS = 32;

  localparam logic signed [33:0] CORDIC_GAIN_Q30 = 34'sd652032874;
  localparam logic [26:0] OMEGA_EARTH_Q40 = 27'd80177662;
  localparam logic [26:0] OMEGA_MARS_Q40 = 27'd77935763;

  localparam logic signed [39:0] POS_MAX = {1'b0, {39{1'b1}}};
  localparam logic signed [39:0] POS_MIN = {1'b1, {39{1'b0}}};
  localparam logic signed [31:0] VEL_MAX = {1'b0, {31{1'b1}}};
  localparam logic signed [31:0] VEL_MIN = {1'b1, {31{1'b0}}};

  localparam logic [0:0] REG_PLANET_SELECT = 1'b0;

  typedef struct packed {
    logic [31:0] hour_angle;
    logic signed [39:0] pos_x_in;
    logic signed [39:0] pos_y_in;
    logic signed [39:0] pos_z_in;
    logic signed [31:0] vel_x_in;
    logic signed [31:0] vel_y_in;
    logic signed [31:0] vel_z_in;
  } in_item_t;

  typedef struct packed {
    logic signed [39:0] pos_x_out;
    logic signed [39:0] pos_y_out;
    logic signed [39:0] pos_z_out;
    logic signed [31:0] vel_x_out;
    logic signed [31:0] vel_y_out;
    logic signed [31:0] vel_z_out;
  } out_item_t;

  function automatic logic signed [33:0] atan_entry(input logic [4:0] i);
    logic [31:0] v;
    unique case (i)
      5'd0: v = 32'h20000000;  5'd1: v = 32'h12E4051E;
      5'd2: v = 32'h09FB385B;  5'd3: v = 32'h051111D4;
      5'd4: v = 32'h028B0D43;  5'd5: v = 32'h0145D7E1;
      5'd6: v = 32'h00A2F61E;  5'd7: v = 32'h00517C55;
      5'd8: v = 32'h0028BE53;  5'd9: v = 32'h00145F2F;
      5'd10: v = 32'h000A2F98; 5'd11: v = 32'h000517CC;
      5'd12: v = 32'h00028BE6; 5'd13: v = 32'h000145F3;
      5'd14: v = 32'h0000A2FA; 5'd15: v = 32'h0000517D;
      5'd16: v = 32'h000028BE; 5'd17: v = 32'h0000145F;
      5'd18: v = 32'h00000A30; 5'd19: v = 32'h00000518;
      5'd20: v = 32'h0000028C; 5'd21: v = 32'h00000146;
      5'd22: v = 32'h000000A3; 5'd23: v = 32'h00000051;
      5'd24: v = 32'h00000029; 5'd25: v = 32'h00000014;
      5'd26: v = 32'h0000000A; 5'd27: v = 32'h00000005;
      5'd28: v = 32'h00000003; 5'd29: v = 32'h00000001;
      5'd30: v = 32'h00000001; 5'd31: v = 32'h00000000;
      default: v = 32'h00000000;
    endcase
    return {2'b00, v};
  endfunction

endpackage

>>> rtl/core/ib_rot_cordic.sv
// Pipelined rotation-mode CORDIC producing cos and sin in Q30, one stage per step.
// Carries an opaque payload alongside. Depends on ib_rot_pkg.
module ib_rot_cordic #(
  parameter int TRIG_ITERATIONS = ib_rot_pkg::TRIG_ITERATIONS_DEF,
  parameter int PW = 8
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  input  logic [31:0] angle,
  input  logic [PW-1:0] in_pay,
  output logic out_valid,
  output logic signed [33:0] cos_out,
  output logic signed [33:0] sin_out,
  output logic [PW-1:0] out_pay
);

  localparam int N = TRIG_ITERATIONS;

  logic [N:0] vld;
  logic signed [33:0] xs [N+1];
  logic signed [33:0] ys [N+1];
  logic signed [33:0] zs [N+1];
  logic [N:0] flip;
  logic [PW-1:0] pay [N+1];

  logic signed [33:0] z0;
  logic big;

  always_comb begin
    z0 = {{2{angle[31]}}, angle};
    big = (z0 > 34'sd1073741824) || (z0 < -34'sd1073741824);
    if (big) begin
      z0 = z0[33] ? z0 + 34'sd2147483648 : z0 - 34'sd2147483648;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else begin
      vld[0] <= in_valid;
    end
    xs[0] <= ib_rot_pkg::CORDIC_GAIN_Q30;
    ys[0] <= '0;
    zs[0] <= z0;
    flip[0] <= big;
    pay[0] <= in_pay;
  end

  for (genvar i = 0; i < N; i++) begin : g_step
    logic signed [33:0] dx, dy, at;
    assign dx = ys[i] >>> i;
    assign dy = xs[i] >>> i;
    assign at = ib_rot_pkg::atan_entry(5'(i));
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else begin
        vld[i+1] <= vld[i];
      end
      if (!zs[i][33]) begin
        xs[i+1] <= xs[i] - dx;
        ys[i+1] <= ys[i] + dy;
        zs[i+1] <= zs[i] - at;
      end else begin
        xs[i+1] <= xs[i] + dx;
        ys[i+1] <= ys[i] - dy;
        zs[i+1] <= zs[i] + at;
      end
      flip[i+1] <= flip[i];
      pay[i+1] <= pay[i];
    end
  end

  assign out_valid = vld[N];
  assign cos_out = flip[N] ? -xs[N] : xs[N];
  assign sin_out = flip[N] ? -ys[N] : ys[N];
  assign out_pay = pay[N];

endmodule

>>> rtl/core/ib_rot_mix.sv
// Pipelined rotation, spin correction, rounding and saturation stages.
// Takes cos and sin from the CORDIC. Depends on ib_rot_pkg.
module ib_rot_mix (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  input  logic signed [33:0] cos_in,
  input  logic signed [33:0] sin_in,
  input  ib_rot_pkg::in_item_t item,
  input  logic planet,
  output logic out_valid,
  output ib_rot_pkg::out_item_t result
);

  // Stage 1: products.
  logic v1;
  logic signed [73:0] pxc, pys, pxs, pyc;
  logic signed [65:0] vxc, vys, vxs, vyc;
  logic signed [39:0] pz1;
  logic signed [31:0] vz1;
  logic w1;
  // Stage 2: rounded rotations.
  logic v2;
  logic signed [44:0] xf2, yf2;
  logic signed [36:0] rvx2, rvy2;
  logic signed [39:0] pz2;
  logic signed [31:0] vz2;
  logic w2;
  // Stage 3: spin products.
  logic v3;
  logic signed [72:0] sx3, sy3;
  logic signed [44:0] xf3, yf3;
  logic signed [36:0] rvx3, rvy3;
  logic signed [39:0] pz3;
  logic signed [31:0] vz3;

  logic signed [74:0] sumx, sumy;
  logic signed [66:0] sumvx, sumvy;
  logic signed [27:0] wq;
  logic signed [37:0] tvx, tvy;

  always_comb begin
    sumx = 75'(pxc) + 75'(pys) + (75'sd1 <<< 29);
    sumy = 75'(pyc) - 75'(pxs) + (75'sd1 <<< 29);
    sumvx = 67'(vxc) + 67'(vys) + (67'sd1 <<< 29);
    sumvy = 67'(vyc) - 67'(vxs) + (67'sd1 <<< 29);
    wq = w2 ? $signed({1'b0, ib_rot_pkg::OMEGA_MARS_Q40})
            : $signed({1'b0, ib_rot_pkg::OMEGA_EARTH_Q40});
    tvx = 38'(rvx3) + 38'((sx3 + (73'sd1 <<< 35)) >>> 36);
    tvy = 38'(rvy3) - 38'((sy3 + (73'sd1 <<< 35) - 73'sd1) >>> 36);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      out_valid <= v3;
    end
    pxc <= item.pos_x_in * cos_in;
    pys <= item.pos_y_in * sin_in;
    pxs <= item.pos_x_in * sin_in;
    pyc <= item.pos_y_in * cos_in;
    vxc <= item.vel_x_in * cos_in;
    vys <= item.vel_y_in * sin_in;
    vxs <= item.vel_x_in * sin_in;
    vyc <= item.vel_y_in * cos_in;
    pz1 <= item.pos_z_in;
    vz1 <= item.vel_z_in;
    w1 <= planet;

    xf2 <= 45'(sumx >>> 30);
    yf2 <= 45'(sumy >>> 30);
    rvx2 <= 37'(sumvx >>> 30);
    rvy2 <= 37'(sumvy >>> 30);
    pz2 <= pz1;
    vz2 <= vz1;
    w2 <= w1;

    sx3 <= yf2 * wq;
    sy3 <= xf2 * wq;
    xf3 <= xf2;
    yf3 <= yf2;
    rvx3 <= rvx2;
    rvy3 <= rvy2;
    pz3 <= pz2;
    vz3 <= vz2;

    result.pos_x_out <= (xf3 > 45'(ib_rot_pkg::POS_MAX)) ? ib_rot_pkg::POS_MAX :
                        (xf3 < 45'(ib_rot_pkg::POS_MIN)) ? ib_rot_pkg::POS_MIN : 40'(xf3);
    result.pos_y_out <= (yf3 > 45'(ib_rot_pkg::POS_MAX)) ? ib_rot_pkg::POS_MAX :
                        (yf3 < 45'(ib_rot_pkg::POS_MIN)) ? ib_rot_pkg::POS_MIN : 40'(yf3);
    result.pos_z_out <= pz3;
    result.vel_x_out <= (tvx > 38'(ib_rot_pkg::VEL_MAX)) ? ib_rot_pkg::VEL_MAX :
                        (tvx < 38'(ib_rot_pkg::VEL_MIN)) ? ib_rot_pkg::VEL_MIN : 32'(tvx);
    result.vel_y_out <= (tvy > 38'(ib_rot_pkg::VEL_MAX)) ? ib_rot_pkg::VEL_MAX :
                        (tvy < 38'(ib_rot_pkg::VEL_MIN)) ? ib_rot_pkg::VEL_MIN : 32'(tvy);
    result.vel_z_out <= vz3;
  end

endmodule

>>> rtl/core/inertial_to_body_fixed_rotation.sv
// Top level of the inertial to body-fixed rotation block.
// Depends on ib_rot_pkg, ib_rot_cordic and ib_rot_mix.
//
// Input channel: a transaction is taken at a clock edge where start is high
// and busy is low. busy is always low, so one state vector can enter every
// cycle. Each result appears on result for exactly one cycle with done high;
// the receiver cannot stall, and none is needed since nothing holds results.
// The path runs through one input register, one register per CORDIC step, then
// four stages of products, rounding, spin products and saturation. Throughput
// is one per cycle. The APB port holds planet_select at byte address 0 (0 Earth,
// 1 Mars); planet_select must be written only while no transaction is in flight,
// and the block itself does not enforce this. Reset (rst, synchronous) clears all
// valid bits and planet_select; items in flight are dropped.
module inertial_to_body_fixed_rotation #(
  parameter int TRIG_ITERATIONS = ib_rot_pkg::TRIG_ITERATIONS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  ib_rot_pkg::in_item_t operand,
  output logic done,
  output ib_rot_pkg::out_item_t result,
  input  logic psel,
  input  logic penable,
  input  logic pwrite,
  input  logic [0:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic pready
);

  localparam int PW = $bits(ib_rot_pkg::in_item_t);

  logic planet;
  logic cv;
  logic signed [33:0] c, s;
  ib_rot_pkg::in_item_t cp;

  assign busy = 1'b0;
  assign pready = 1'b1;
  assign prdata = {31'd0, planet};

  always_ff @(posedge clk) begin
    if (rst) begin
      planet <= 1'b0;
    end else if (psel && penable && pwrite && paddr == ib_rot_pkg::REG_PLANET_SELECT) begin
      planet <= pwdata[0];
    end
  end

  ib_rot_cordic #(.TRIG_ITERATIONS(TRIG_ITERATIONS), .PW(PW)) u_cordic (
    .clk(clk), .rst(rst), .in_valid(start), .angle(operand.hour_angle),
    .in_pay(operand), .out_valid(cv), .cos_out(c), .sin_out(s), .out_pay(cp)
  );

  ib_rot_mix u_mix (
    .clk(clk), .rst(rst), .in_valid(cv), .cos_in(c), .sin_in(s), .item(cp),
    .planet(planet), .out_valid(done), .result(result)
  );

endmodule

>>> rtl/core/ib_rot_checker.sv
// Port-level checker for the inertial to body-fixed rotation block.
// Bound to the top level. Depends on ib_rot_pkg.
module ib_rot_checker #(
  parameter int LATENCY = ib_rot_pkg::TRIG_ITERATIONS_DEF + 5
) (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic done,
  input ib_rot_pkg::out_item_t result,
  input logic pready
);

  a_never_busy: assert property (@(posedge clk) busy == 1'b0)
    else $error("busy raised");
  a_ready: assert property (@(posedge clk) pready)
    else $error("pready low");
  a_reset_quiet: assert property (@(posedge clk) rst |=> !done)
    else $error("done right after reset");
  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start, LATENCY)) else $error("result without transaction");
  a_known_result: assert property (@(posedge clk) disable iff (rst)
    done |-> !$isunknown(result)) else $error("unknown result");

endmodule

bind inertial_to_body_fixed_rotation ib_rot_checker #(.LATENCY(TRIG_ITERATIONS + 5)) u_chk (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .done(done),
  .result(result), .pready(pready)
);

>>> verif/tb_inertial_to_body_fixed_rotation.sv
// Self-checking testbench for the inertial to body-fixed rotation block.
// Predicts each state vector with its own CORDIC and fixed-point rotation.
// Depends on ib_rot_pkg and inertial_to_body_fixed_rotation.
module tb_inertial_to_body_fixed_rotation;

  localparam int LATENCY = ib_rot_pkg::TRIG_ITERATIONS_DEF + 5;
  localparam longint GAIN = 652032874;
  localparam longint W_EARTH = 80177662;
  localparam longint W_MARS = 77935763;

  logic clk, rst, start, busy, done;
  ib_rot_pkg::in_item_t operand;
  ib_rot_pkg::out_item_t result;
  logic psel, penable, pwrite, pready;
  logic [0:0] paddr;
  logic [31:0] pwdata, prdata;

  ib_rot_pkg::out_item_t rotated_q[$];
  logic planet_sel;
  int errors, sent_count, checked_count, send_idle_pct;

  inertial_to_body_fixed_rotation dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .operand(operand),
    .done(done), .result(result), .psel(psel), .penable(penable),
    .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
    .pready(pready)
  );

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  initial begin
    #600000;
    $display("DONE: errors detected");
    $finish;
  end

  function automatic void sin_cos(input logic [31:0] ang, output longint c, output longint s);
    longint z, x, y, dx, dy;
    bit flip;
    z = longint'($signed(ang));
    x = GAIN;
    y = 0;
    flip = 0;
    if (z > (64'sd1 <<< 30) || z < -(64'sd1 <<< 30)) begin
      flip = 1;
      z += (z > 0) ? -(64'sd1 <<< 31) : (64'sd1 <<< 31);
    end
    for (int i = 0; i < ib_rot_pkg::TRIG_ITERATIONS_DEF; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= longint'(ib_rot_pkg::atan_entry(i[4:0]));
      end else begin
        x += dx; y -= dy; z += longint'(ib_rot_pkg::atan_entry(i[4:0]));
      end
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endfunction

  function automatic logic signed [127:0] round_shift(input logic signed [127:0] v, int sh);
    return (v + (128'sd1 <<< (sh - 1))) >>> sh;
  endfunction

  function automatic logic signed [127:0] clamp(input logic signed [127:0] v,
                                                 logic signed [127:0] lo,
                                                 logic signed [127:0] hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic ib_rot_pkg::out_item_t rotate_state(input ib_rot_pkg::in_item_t it,
                                                         logic sel);
    longint c, s;
    logic signed [127:0] cw, sw, px, py, vx, vy, w, xf, yf, rvx, rvy;
    ib_rot_pkg::out_item_t r;
    sin_cos(it.hour_angle, c, s);
    cw = 128'(c);
    sw = 128'(s);
    px = 128'(it.pos_x_in);
    py = 128'(it.pos_y_in);
    vx = 128'(it.vel_x_in);
    vy = 128'(it.vel_y_in);
    w = sel ? 128'(W_MARS) : 128'(W_EARTH);
    xf = round_shift(px * cw + py * sw, 30);
    yf = round_shift(py * cw - px * sw, 30);
    rvx = round_shift(vx * cw + vy * sw, 30) + round_shift(yf * w, 36);
    rvy = round_shift(vy * cw - vx * sw, 30) + round_shift(-(xf * w), 36);
    r.pos_x_out = 40'(clamp(xf, 128'(ib_rot_pkg::POS_MIN), 128'(ib_rot_pkg::POS_MAX)));
    r.pos_y_out = 40'(clamp(yf, 128'(ib_rot_pkg::POS_MIN), 128'(ib_rot_pkg::POS_MAX)));
    r.pos_z_out = it.pos_z_in;
    r.vel_x_out = 32'(clamp(rvx, 128'(ib_rot_pkg::VEL_MIN), 128'(ib_rot_pkg::VEL_MAX)));
    r.vel_y_out = 32'(clamp(rvy, 128'(ib_rot_pkg::VEL_MIN), 128'(ib_rot_pkg::VEL_MAX)));
    r.vel_z_out = it.vel_z_in;
    return r;
  endfunction

  task automatic check_field(input string name, logic [39:0] exp_v, logic [39:0] act_v);
    if (exp_v !== act_v) begin
      errors++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
    end
  endtask

  always @(posedge clk) begin
    ib_rot_pkg::out_item_t e;
    if (!rst && done) begin
      if (rotated_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual %h", $time, result);
      end else begin
        e = rotated_q.pop_front();
        checked_count++;
        check_field("pos_x_out", e.pos_x_out, result.pos_x_out);
        check_field("pos_y_out", e.pos_y_out, result.pos_y_out);
        check_field("pos_z_out", e.pos_z_out, result.pos_z_out);
        check_field("vel_x_out", 40'(e.vel_x_out), 40'(result.vel_x_out));
        check_field("vel_y_out", 40'(e.vel_y_out), 40'(result.vel_y_out));
        check_field("vel_z_out", 40'(e.vel_z_out), 40'(result.vel_z_out));
      end
    end
  end

  task automatic send_state(input ib_rot_pkg::in_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk);
      start <= 1'b0;
    end
    @(negedge clk);
    start <= 1'b1;
    operand <= it;
    while (busy) @(negedge clk);
    rotated_q.push_back(rotate_state(it, planet_sel));
    sent_count++;
    @(posedge clk);
  endtask

  task automatic drain;
    @(negedge clk);
    start <= 1'b0;
    while (rotated_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
  endtask

  task automatic set_planet(input logic sel);
    @(negedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= ib_rot_pkg::REG_PLANET_SELECT; pwdata <= {$urandom} & ~32'h1 | 32'(sel);
    @(negedge clk);
    penable <= 1'b1;
    while (!pready) @(negedge clk);
    @(negedge clk);
    planet_sel = sel;
    pwrite <= 1'b0; penable <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata[0] !== sel) begin
      errors++;
      $display("%0t: planet_select readback mismatch, expected %b, actual %b",
               $time, sel, prdata[0]);
    end
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0;
  endtask

  function automatic logic [39:0] rand_pos(input bit full);
    logic [39:0] v;
    v = 40'({$urandom, $urandom});
    if (!full) v = 40'($signed(v[30:0]));
    return v;
  endfunction

  function automatic ib_rot_pkg::in_item_t rand_state;
    ib_rot_pkg::in_item_t it;
    bit full;
    full = 1'($urandom_range(1));
    it.hour_angle = $urandom;
    it.pos_x_in = rand_pos(full);
    it.pos_y_in = rand_pos(full);
    it.pos_z_in = rand_pos(1'($urandom_range(1)));
    it.vel_x_in = $urandom_range(3) == 0 ? $urandom : 32'($signed(16'($urandom)));
    it.vel_y_in = $urandom_range(3) == 0 ? $urandom : 32'($signed(16'($urandom)));
    it.vel_z_in = $urandom;
    return it;
  endfunction

  task automatic test_directed;
    logic [31:0] angles[12];
    ib_rot_pkg::in_item_t it;
    angles = '{32'h0, 32'h40000000, 32'h40000001, 32'hC0000000, 32'hBFFFFFFF,
               32'h80000000, 32'h20000000, 32'hE0000000, 32'h7FFFFFFF, 32'hFFFFFFFF,
               32'h00000001, 32'h60000000};
    foreach (angles[i]) begin
      it = rand_state();
      it.hour_angle = angles[i];
      send_state(it);
    end
    // Full-scale positions and velocities at 45 degrees force saturation.
    it = '{32'h20000000, ib_rot_pkg::POS_MAX, ib_rot_pkg::POS_MAX, ib_rot_pkg::POS_MAX,
           ib_rot_pkg::VEL_MAX, ib_rot_pkg::VEL_MAX, ib_rot_pkg::VEL_MAX};
    send_state(it);
    it = '{32'hE0000000, ib_rot_pkg::POS_MIN, ib_rot_pkg::POS_MAX, ib_rot_pkg::POS_MIN,
           ib_rot_pkg::VEL_MIN, ib_rot_pkg::VEL_MAX, ib_rot_pkg::VEL_MIN};
    send_state(it);
    it = '{32'hA0000000, ib_rot_pkg::POS_MIN, ib_rot_pkg::POS_MIN, 40'sd0,
           ib_rot_pkg::VEL_MIN, ib_rot_pkg::VEL_MIN, 32'sd0};
    send_state(it);
    it = '{32'h60000000, ib_rot_pkg::POS_MAX, ib_rot_pkg::POS_MIN, 40'sd0,
           ib_rot_pkg::VEL_MAX, ib_rot_pkg::VEL_MIN, 32'sd0};
    send_state(it);
    it = '{32'h0, 40'sd0, 40'sd0, 40'sd0, 32'sd0, 32'sd0, 32'sd0};
    send_state(it);
    // Large position with zero velocity makes the spin term dominate.
    it = '{32'h12345678, 40'sd1 <<< 38, -(40'sd1 <<< 37), 40'sd5, 32'sd0, 32'sd0, -32'sd1};
    send_state(it);
  endtask

  task automatic test_random(input int count);
    repeat (count) send_state(rand_state());
  endtask

  initial begin
    rst = 1; start = 0; operand = '0;
    psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
    planet_sel = 0; errors = 0; sent_count = 0; checked_count = 0;
    send_idle_pct = 19;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    test_directed();
    drain();
    set_planet(1'b1);
    test_directed();
    test_random(300);
    drain();
    set_planet(1'b0);
    send_idle_pct = 80;
    test_random(300);
    drain();
    set_planet(1'b1);
    send_idle_pct = 0;
    test_random(400);
    drain();
    $display("Sent %0d state vectors, checked %0d results,", sent_count, checked_count);
    $display("across both planet rates, angle quadrant edges and saturation cases.");
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule

>>> sim.f
rtl/core/ib_rot_pkg.sv
rtl/core/ib_rot_cordic.sv
rtl/core/ib_rot_mix.sv
rtl/core/inertial_to_body_fixed_rotation.sv
rtl/core/ib_rot_checker.sv
verif/tb_inertial_to_body_fixed_rotation.sv
